[src/dlr_pkg.sv]
package dlr_pkg;

   localparam int COORD_BITS_DEF = 11;
   localparam int FRAC_BITS_DEF  = 16;

   // Request kinds carried on req_type.
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_STEP = 1'b1;

   // Status returned by the shared divider to its sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

[src/dlr_div.sv]
module dlr_div #(
   parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COORD_BITS-1:0] mag,
   input  logic [COORD_BITS-1:0] divisor,
   output logic [FRAC_BITS:0]    quot,
   output dlr_pkg::div_stat_type stat
);

   localparam int CNT_W = $clog2(FRAC_BITS + 2);

   logic [COORD_BITS:0]   rem_ff, rem_in;
   logic [COORD_BITS-1:0] divisor_ff, divisor_in;
   logic [FRAC_BITS:0]    quot_ff, quot_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  fits;
   logic [COORD_BITS:0]   diff;

   // One quotient bit per cycle. The magnitude never exceeds the divisor, so
   // the quotient needs FRAC_BITS+1 bits and the remainder COORD_BITS+1 bits.
   always_comb begin
      fits       = rem_ff >= {1'b0, divisor_ff};
      diff       = fits ? (rem_ff - {1'b0, divisor_ff}) : rem_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quot_in    = quot_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         rem_in     = {1'b0, mag};
         divisor_in = divisor;
         quot_in    = '0;
         cnt_in     = CNT_W'(FRAC_BITS + 1);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in  = {diff[COORD_BITS-1:0], 1'b0};
         quot_in = {quot_ff[FRAC_BITS-1:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quot_ff    <= quot_in;
   end

   assign quot      = quot_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider reports done while still busy");

   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("divider busy with an exhausted bit counter");

   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a preceding iteration");

endmodule

[src/dda_line_rasterizer_top.sv]
// A request's pixel appears on the rsp_ port in the cycle after acceptance.
// Step requests are taken one per cycle while the line is active and the result register is free.
// A load request of a non-empty line stalls further requests until both increments are known:
// both come from one restoring divider producing one quotient bit per cycle.
// Reset is synchronous and active high; it empties the result register and idles the line.
module dda_line_rasterizer_top #(
   parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_type,
   input  logic [COORD_BITS-1:0] req_x_start,
   input  logic [COORD_BITS-1:0] req_y_start,
   input  logic [COORD_BITS-1:0] req_x_end,
   input  logic [COORD_BITS-1:0] req_y_end,
   input  logic [3:0]            req_line_color,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COORD_BITS-1:0] rsp_pixel_x,
   output logic [COORD_BITS-1:0] rsp_pixel_y,
   output logic [3:0]            rsp_pixel_color,
   output logic                  rsp_last_pixel
);

   localparam int ACC_W = COORD_BITS + FRAC_BITS;
   localparam int INC_W = FRAC_BITS + 2;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DIV_X = 2'd1;
   localparam logic [1:0] ST_DIV_Y = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [ACC_W-1:0]      acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic [INC_W-1:0]      inc_x_ff, inc_x_in, inc_y_ff, inc_y_in;
   logic [COORD_BITS-1:0] steps_left_ff, steps_left_in;
   logic [3:0]            color_ff, color_in;
   logic                  active_ff, active_in;
   logic                  neg_x_ff, neg_y_ff, neg_x_in, neg_y_in;
   logic [COORD_BITS-1:0] ay_ff, ay_in;

   logic                  out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [3:0]            out_color_ff, out_color_in;
   logic                  out_last_ff, out_last_in;

   logic                  accept, slot_free;
   logic signed [COORD_BITS:0] dx, dy;
   logic [COORD_BITS:0]   dx_abs, dy_abs;
   logic [COORD_BITS-1:0] ax, ay, steps;
   logic                  div_start;
   logic [COORD_BITS-1:0] div_mag, div_divisor;
   logic [FRAC_BITS:0]    quot;
   dlr_pkg::div_stat_type div_stat;
   logic [INC_W-1:0]      quot_signed;
   logic                  do_advance;

   assign slot_free = !out_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == ST_IDLE && slot_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      dx     = $signed({1'b0, req_x_end}) - $signed({1'b0, req_x_start});
      dy     = $signed({1'b0, req_y_end}) - $signed({1'b0, req_y_start});
      dx_abs = dx[COORD_BITS] ? (-dx) : dx;
      dy_abs = dy[COORD_BITS] ? (-dy) : dy;
      ax     = dx_abs[COORD_BITS-1:0];
      ay     = dy_abs[COORD_BITS-1:0];
      steps  = (ax > ay) ? ax : ay;
   end

   // The divider is shared: the x increment first, then the y increment.
   assign div_start   = (accept && req_type == dlr_pkg::REQ_LOAD && steps != '0) ||
                        (state_ff == ST_DIV_X && div_stat.done);
   assign div_mag     = (state_ff == ST_IDLE) ? ax : ay_ff;
   assign div_divisor = (state_ff == ST_IDLE) ? steps : steps_left_ff;

   dlr_div #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .mag     (div_mag),
      .divisor (div_divisor),
      .quot    (quot),
      .stat    (div_stat)
   );

   always_comb begin
      logic neg;
      neg         = (state_ff == ST_DIV_X) ? neg_x_ff : neg_y_ff;
      quot_signed = neg ? (INC_W'(0) - {1'b0, quot}) : {1'b0, quot};
   end

   always_comb begin
      state_in      = state_ff;
      acc_x_in      = acc_x_ff;
      acc_y_in      = acc_y_ff;
      inc_x_in      = inc_x_ff;
      inc_y_in      = inc_y_ff;
      steps_left_in = steps_left_ff;
      color_in      = color_ff;
      active_in     = active_ff;
      neg_x_in      = neg_x_ff;
      neg_y_in      = neg_y_ff;
      ay_in         = ay_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_color_in  = out_color_ff;
      out_last_in   = out_last_ff;
      do_advance    = 1'b0;

      if (accept && req_type == dlr_pkg::REQ_LOAD) begin
         acc_x_in      = {req_x_start, FRAC_BITS'(0)};
         acc_y_in      = {req_y_start, FRAC_BITS'(0)};
         color_in      = req_line_color;
         steps_left_in = steps;
         neg_x_in      = dx[COORD_BITS];
         neg_y_in      = dy[COORD_BITS];
         ay_in         = ay;
         inc_x_in      = '0;
         inc_y_in      = '0;
         out_valid_in  = 1'b1;
         out_x_in      = req_x_start;
         out_y_in      = req_y_start;
         out_color_in  = req_line_color;
         out_last_in   = (steps == '0);
         active_in     = (steps != '0);
         if (steps != '0) begin
            state_in = ST_DIV_X;
         end
      end else if (accept && active_ff) begin
         steps_left_in = steps_left_ff - COORD_BITS'(1);
         out_valid_in  = 1'b1;
         out_x_in      = acc_x_ff[ACC_W-1:FRAC_BITS];
         out_y_in      = acc_y_ff[ACC_W-1:FRAC_BITS];
         out_color_in  = color_ff;
         out_last_in   = (steps_left_ff == COORD_BITS'(1));
         if (steps_left_ff == COORD_BITS'(1)) begin
            active_in = 1'b0;
         end
         do_advance = 1'b1;
      end

      case (state_ff)
         ST_DIV_X: begin
            if (div_stat.done) begin
               inc_x_in = quot_signed;
               state_in = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (div_stat.done) begin
               inc_y_in   = quot_signed;
               state_in   = ST_IDLE;
               do_advance = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // The load's first pixel has already gone out, so the accumulators
      // advance as soon as the y increment is known.
      if (do_advance) begin
         acc_x_in = acc_x_ff + {{(ACC_W - INC_W){inc_x_in[INC_W-1]}}, inc_x_in};
         acc_y_in = acc_y_ff + {{(ACC_W - INC_W){inc_y_in[INC_W-1]}}, inc_y_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_ff     <= 1'b0;
         out_valid_ff  <= 1'b0;
         acc_x_ff      <= '0;
         acc_y_ff      <= '0;
         inc_x_ff      <= '0;
         inc_y_ff      <= '0;
         steps_left_ff <= '0;
         color_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         out_valid_ff  <= out_valid_in;
         acc_x_ff      <= acc_x_in;
         acc_y_ff      <= acc_y_in;
         inc_x_ff      <= inc_x_in;
         inc_y_ff      <= inc_y_in;
         steps_left_ff <= steps_left_in;
         color_ff      <= color_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_x_ff     <= neg_x_in;
      neg_y_ff     <= neg_y_in;
      ay_ff        <= ay_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_color_ff <= out_color_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_x     = out_x_ff;
   assign rsp_pixel_y     = out_y_ff;
   assign rsp_pixel_color = out_color_ff;
   assign rsp_last_pixel  = out_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      accept |-> state_ff == ST_IDLE)
      else $error("request accepted while the divider sequence is running");

   assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider restarted while busy");

   assert property (@(posedge clock) disable iff (reset)
      (active_ff && state_ff == ST_IDLE) |-> steps_left_ff != '0)
      else $error("active line with no pixels left");

   assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(accept))
      else $error("result appeared without an accepted request");

endmodule

[tb/sv/tb_top.sv]
localparam int CB    = dlr_pkg::COORD_BITS_DEF;
localparam int FB    = dlr_pkg::FRAC_BITS_DEF;
localparam int ACC_W = CB + FB;
localparam int INC_W = FB + 2;
localparam int COORD_MAX = (1 << CB) - 1;

typedef struct packed {
   logic [CB-1:0] x;
   logic [CB-1:0] y;
   logic [3:0]    color;
   logic          last;
} pixel_type;

function automatic int magnitude(int v);
   return (v < 0) ? -v : v;
endfunction

class pixel_scoreboard;
   logic [ACC_W-1:0]        pos_x, pos_y;
   logic signed [INC_W-1:0] inc_x, inc_y;
   logic [CB-1:0]           steps_left;
   logic [3:0]              held_color;
   bit                      line_active;
   pixel_type               expected_pixels[$];
   int                      predicted;
   int                      errors;

   function new();
      pos_x = '0;
      pos_y = '0;
      inc_x = '0;
      inc_y = '0;
      steps_left = '0;
      held_color = '0;
      line_active = 0;
      predicted = 0;
      errors = 0;
   endfunction

   // Per-step increment in signed fixed point, truncated toward zero.
   function logic signed [INC_W-1:0] step_increment(int d, int steps);
      longint unsigned mag, q;
      mag = 64'(magnitude(d));
      q = (mag << FB) / 64'(steps);
      if (d < 0)
         q = 64'd0 - q;
      return q[INC_W-1:0];
   endfunction

   function void advance();
      pos_x = pos_x + {{(ACC_W-INC_W){inc_x[INC_W-1]}}, inc_x};
      pos_y = pos_y + {{(ACC_W-INC_W){inc_y[INC_W-1]}}, inc_y};
   endfunction

   function void push_pixel(bit last);
      pixel_type p;
      p.x = pos_x[ACC_W-1:FB];
      p.y = pos_y[ACC_W-1:FB];
      p.color = held_color;
      p.last = last;
      expected_pixels.push_back(p);
      predicted++;
   endfunction

   function int pending();
      return expected_pixels.size();
   endfunction

   function void note_request(logic kind, logic [CB-1:0] xs, logic [CB-1:0] ys,
                              logic [CB-1:0] xe, logic [CB-1:0] ye, logic [3:0] col);
      int dx, dy, steps;
      bit last;
      if (kind == dlr_pkg::REQ_LOAD) begin
         dx = int'(xe) - int'(xs);
         dy = int'(ye) - int'(ys);
         steps = (magnitude(dx) > magnitude(dy)) ? magnitude(dx) : magnitude(dy);
         held_color = col;
         pos_x = {xs, {FB{1'b0}}};
         pos_y = {ys, {FB{1'b0}}};
         if (steps == 0) begin
            inc_x = '0;
            inc_y = '0;
            steps_left = '0;
            line_active = 0;
            push_pixel(1);
         end else begin
            inc_x = step_increment(dx, steps);
            inc_y = step_increment(dy, steps);
            steps_left = steps[CB-1:0];
            line_active = 1;
            push_pixel(0);
            advance();
         end
      end else if (line_active) begin
         steps_left = steps_left - CB'(1);
         last = (steps_left == 0);
         push_pixel(last);
         if (last)
            line_active = 0;
         advance();
      end
   endfunction

   function void check_pixel(pixel_type got);
      pixel_type e;
      if (expected_pixels.size() == 0) begin
         $error("unexpected pixel x=%0d y=%0d color=%0d last=%0d",
                got.x, got.y, got.color, got.last);
         errors++;
         return;
      end
      e = expected_pixels.pop_front();
      if (got.x !== e.x) begin
         $error("pixel_x: expected %0d, got %0d", e.x, got.x);
         errors++;
      end
      if (got.y !== e.y) begin
         $error("pixel_y: expected %0d, got %0d", e.y, got.y);
         errors++;
      end
      if (got.color !== e.color) begin
         $error("pixel_color: expected %0d, got %0d", e.color, got.color);
         errors++;
      end
      if (got.last !== e.last) begin
         $error("last_pixel: expected %0d, got %0d", e.last, got.last);
         errors++;
      end
   endfunction
endclass

module tb_top;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int PIXEL_TARGET = 1620;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid;
   logic          req_stall;
   logic          req_type;
   logic [CB-1:0] req_x_start;
   logic [CB-1:0] req_y_start;
   logic [CB-1:0] req_x_end;
   logic [CB-1:0] req_y_end;
   logic [3:0]    req_line_color;
   logic          rsp_valid;
   logic          rsp_stall;
   logic [CB-1:0] rsp_pixel_x;
   logic [CB-1:0] rsp_pixel_y;
   logic [3:0]    rsp_pixel_color;
   logic          rsp_last_pixel;

   pixel_scoreboard board = new();
   int cycle_count = 0;
   bit sender_rush = 0;
   bit receiver_rush = 0;
   bit long_hold = 0;

   dda_line_rasterizer_top DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_x_start(req_x_start),
      .req_y_start(req_y_start),
      .req_x_end(req_x_end),
      .req_y_end(req_y_end),
      .req_line_color(req_line_color),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pixel_x(rsp_pixel_x),
      .rsp_pixel_y(rsp_pixel_y),
      .rsp_pixel_color(rsp_pixel_color),
      .rsp_last_pixel(rsp_last_pixel)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Outputs are sampled mid-cycle, once everything driven at the edge has settled.
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_pixel('{rsp_pixel_x, rsp_pixel_y, rsp_pixel_color, rsp_last_pixel});
   end

   initial begin : pixel_receiver
      int wait_cycles;
      bit taken;
      rsp_stall <= 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (long_hold) begin
            wait_cycles = 250;
            long_hold = 0;
         end else if (receiver_rush) begin
            wait_cycles = 0;
         end else begin
            wait_cycles = $urandom_range(0, 15);
         end
         if ($urandom_range(0, 99) < 3)
            receiver_rush = !receiver_rush;
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         taken = 0;
         while (!taken) begin
            @(negedge clock);
            taken = rsp_valid;
            @(posedge clock);
         end
      end
   end

   task automatic send_request(logic kind, int xs, int ys, int xe, int ye, int col);
      int gap;
      bit taken;
      gap = sender_rush ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_x_start <= xs[CB-1:0];
      req_y_start <= ys[CB-1:0];
      req_x_end <= xe[CB-1:0];
      req_y_end <= ye[CB-1:0];
      req_line_color <= col[3:0];
      taken = 0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      board.note_request(kind, xs[CB-1:0], ys[CB-1:0], xe[CB-1:0], ye[CB-1:0], col[3:0]);
   endtask

   // The endpoint fields are ignored on a step, so they carry noise.
   task automatic send_step();
      send_request(dlr_pkg::REQ_STEP, $urandom_range(0, COORD_MAX),
                   $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                   $urandom_range(0, COORD_MAX), $urandom_range(0, 15));
   endtask

   task automatic run_line(int xs, int ys, int xe, int ye, int col, int n);
      send_request(dlr_pkg::REQ_LOAD, xs, ys, xe, ye, col);
      repeat (n) send_step();
   endtask

   function automatic int clamp_coord(int v);
      return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
   endfunction

   task automatic random_line();
      int sel, span, xs, ys, xe, ye, len, n;
      sel = $urandom_range(0, 99);
      span = (sel < 70) ? 15 : (sel < 90) ? 100 : COORD_MAX;
      xs = $urandom_range(0, COORD_MAX);
      ys = $urandom_range(0, COORD_MAX);
      if (sel >= 6 && sel < 10) begin
         xs = $urandom_range(0, 1) * COORD_MAX;
         ys = $urandom_range(0, 1) * COORD_MAX;
      end
      xe = clamp_coord(xs + $urandom_range(0, 2 * span) - span);
      ye = clamp_coord(ys + $urandom_range(0, 2 * span) - span);
      if (sel < 6) begin
         xe = xs;
         ye = ys;
      end
      len = magnitude(xe - xs);
      if (magnitude(ye - ys) > len)
         len = magnitude(ye - ys);
      // Long lines are cut short by the next load so that the run stays brief.
      if (span == COORD_MAX)
         n = $urandom_range(0, 30);
      else if ($urandom_range(0, 99) < 85)
         n = len + $urandom_range(0, 2);
      else
         n = $urandom_range(0, len);
      if ($urandom_range(0, 9) == 0)
         sender_rush = !sender_rush;
      run_line(xs, ys, xe, ye, $urandom_range(0, 15), n);
   endtask

   task automatic drain_pixels();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   initial begin : stimulus
      bit held, paused;
      held = 0;
      paused = 0;
      req_valid <= 1'b0;
      req_type <= dlr_pkg::REQ_LOAD;
      req_x_start <= '0;
      req_y_start <= '0;
      req_x_end <= '0;
      req_y_end <= '0;
      req_line_color <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_step();
      run_line(0, 0, 0, 0, 0, 0);
      run_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 15, 1);
      run_line(0, 0, COORD_MAX, COORD_MAX, 15, 2);
      // A new line while the previous one is still being drawn.
      run_line(COORD_MAX, 0, 0, COORD_MAX, 10, 2);
      run_line(COORD_MAX, COORD_MAX, 0, 0, 5, 1);
      run_line(3, 5, 7, 1, 9, 5);
      run_line(100, 0, 0, 3, 6, 2);
      run_line(0, COORD_MAX, 1, 0, 12, 1);

      while (board.predicted < PIXEL_TARGET) begin
         if (!held && board.predicted >= 400) begin
            held = 1;
            long_hold = 1;
            sender_rush = 1;
            run_line(200, 300, 260, 330, 7, 60);
         end else if (!paused && board.predicted >= 900) begin
            paused = 1;
            drain_pixels();
         end else begin
            random_line();
         end
      end

      drain_pixels();
      repeat (50) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
